@@ rtl/fcit_pkg.sv @@
// Package for the frequency correction interpolation table.
// Holds the word types, point layout, controller states and sizing constants.
// No dependencies.
package fcit_pkg;

   localparam int MaxPointsDefault = 64;
   localparam int FreqWidth        = 32;
   localparam int CorrWidth        = 16;
   localparam int HzWidth          = 40;
   localparam int ProdWidth        = 48;
   localparam int Div10Chunk       = 8;
   localparam int Div10Steps       = HzWidth / Div10Chunk;
   localparam int DivSteps         = ProdWidth;
   localparam int StepWidth        = 6;
   localparam logic [FreqWidth-1:0] DefaultFreq = 32'd100000000;
   localparam logic [3:0]           HzPerLsb    = 4'd10;
   localparam logic [15:0]          Recip10     = 16'd52429;
   localparam int                   Recip10Shift = 19;

   typedef struct packed {
      logic                        cmd;
      logic                        table_sel;
      logic [HzWidth-1:0]          query_freq_hz;
      logic [7:0]                  point_index;
      logic [7:0]                  point_total;
      logic [FreqWidth-1:0]        point_freq;
      logic signed [CorrWidth-1:0] port1_value;
      logic signed [CorrWidth-1:0] port2_value;
   } req_type;

   typedef struct packed {
      logic signed [CorrWidth-1:0] port1_corr;
      logic signed [CorrWidth-1:0] port2_corr;
   } rsp_type;

   typedef struct packed {
      logic [FreqWidth-1:0]        freq;
      logic signed [CorrWidth-1:0] p1;
      logic signed [CorrWidth-1:0] p2;
   } point_type;

   localparam logic CmdQuery = 1'b0;
   localparam logic CmdWrite = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV10,
      ST_READ,
      ST_CMP,
      ST_MUL,
      ST_DIV,
      ST_OUT_CUR,
      ST_OUT_PREV,
      ST_OUT_LERP
   } state_type;

   typedef enum logic [1:0] {
      SEL_CUR,
      SEL_PREV,
      SEL_LERP
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        write;
      logic        div10_step;
      logic        search_init;
      logic        rd_en;
      logic        advance;
      logic        mul;
      logic        div_step;
      logic        res_load;
      res_sel_type res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic idx_zero;
      logic at_end;
      logic rsp_free;
   } dp_status_type;

endpackage

@@ rtl/fcit_ctrl.sv @@
// Controller state machine for the interpolation table.
// Accepts write words and sequences divide-by-ten, table search, multiply, divide and result load.
// Depends on fcit_pkg.
module fcit_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  fcit_pkg::dp_status_type status,
   output fcit_pkg::dp_cmd_type    cmd
);

   fcit_pkg::state_type state_ff, state_in;
   logic [fcit_pkg::StepWidth-1:0] step_ff, step_in;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcit_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd         = '0;
      cmd.res_sel = fcit_pkg::SEL_CUR;
      req_ready   = 1'b0;
      accept      = 1'b0;
      case (state_ff)
         fcit_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               if (req_cmd == fcit_pkg::CmdWrite) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  step_in  = '0;
                  state_in = fcit_pkg::ST_DIV10;
               end
            end
         end
         fcit_pkg::ST_DIV10: begin
            cmd.div10_step = 1'b1;
            step_in        = step_ff + 1'b1;
            if (step_ff == fcit_pkg::StepWidth'(fcit_pkg::Div10Steps - 1)) begin
               cmd.search_init = 1'b1;
               state_in        = fcit_pkg::ST_READ;
            end
         end
         fcit_pkg::ST_READ: begin
            if (status.at_end) begin
               state_in = fcit_pkg::ST_OUT_PREV;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = fcit_pkg::ST_CMP;
            end
         end
         fcit_pkg::ST_CMP: begin
            if (status.hit) begin
               state_in = status.idx_zero ? fcit_pkg::ST_OUT_CUR : fcit_pkg::ST_MUL;
            end else begin
               cmd.advance = 1'b1;
               state_in    = fcit_pkg::ST_READ;
            end
         end
         fcit_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = '0;
            state_in = fcit_pkg::ST_DIV;
         end
         fcit_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == fcit_pkg::StepWidth'(fcit_pkg::DivSteps - 1)) begin
               state_in = fcit_pkg::ST_OUT_LERP;
            end
         end
         fcit_pkg::ST_OUT_CUR, fcit_pkg::ST_OUT_PREV, fcit_pkg::ST_OUT_LERP: begin
            if (state_ff == fcit_pkg::ST_OUT_PREV) begin
               cmd.res_sel = fcit_pkg::SEL_PREV;
            end else if (state_ff == fcit_pkg::ST_OUT_LERP) begin
               cmd.res_sel = fcit_pkg::SEL_LERP;
            end
            if (status.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = fcit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcit_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/fcit_dpath.sv @@
// Datapath for the interpolation table: point memory, used counts,
// chunked divide-by-ten, search registers, multiplier, divider lanes, result.
// Depends on fcit_pkg.
module fcit_dpath #(
   parameter int MAX_POINTS = fcit_pkg::MaxPointsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fcit_pkg::req_type       req_data,
   input  fcit_pkg::dp_cmd_type    cmd,
   output fcit_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fcit_pkg::rsp_type       rsp_data
);

   localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int AW    = IW + 1;
   localparam int Depth = 2 ** AW;
   localparam logic [7:0] MaxP = 8'(MAX_POINTS);
   localparam int NW    = fcit_pkg::Div10Chunk + 4;

   fcit_pkg::point_type mem [Depth];
   logic [Depth-1:0]    valid_ff;
   logic [7:0]          used_ff [2];

   fcit_pkg::point_type mem_q_ff;
   logic                rd_valid_ff, rd_zero_ff;
   fcit_pkg::point_type cur_pt, prev_ff;

   logic                              tsel_ff;
   logic [fcit_pkg::HzWidth-1:0]      sh_ff;
   logic [3:0]                        rem10_ff;
   logic [NW-1:0]                     n10;
   logic [NW+15:0]                    prod10;
   logic [fcit_pkg::Div10Chunk-1:0]   q10;
   logic [NW-1:0]                     back10;
   logic [7:0]                        idx_ff;
   logic [7:0]                        used_sel, used_eff;

   logic [fcit_pkg::FreqWidth-1:0] num, den_ff;
   logic signed [16:0]             diff1, diff2;
   logic signed [50:0]             prod1, prod2;
   logic [fcit_pkg::ProdWidth-1:0] dvd1_ff, dvd2_ff;
   logic [31:0]                    rem1_ff, rem2_ff;
   logic [32:0]                    rsh1, rsh2;
   logic                           sgn1_ff, sgn2_ff;
   logic                           ge1, ge2;
   logic signed [17:0]             q1, q2, sum1, sum2;

   logic                rsp_valid_ff;
   fcit_pkg::rsp_type   rsp_ff, rsp_in;

   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_ok;

   assign wr_addr = {req_data.table_sel, req_data.point_index[IW-1:0]};
   assign rd_addr = {tsel_ff, idx_ff[IW-1:0]};
   assign wr_ok   = cmd.write && (req_data.point_index < MaxP);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr] <= {req_data.point_freq, req_data.port1_value, req_data.port2_value};
      end
      if (cmd.rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_zero_ff  <= (idx_ff == 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         used_ff[0] <= 8'd1;
         used_ff[1] <= 8'd1;
      end else if (wr_ok) begin
         valid_ff[wr_addr] <= 1'b1;
         if (req_data.point_total != 8'd0 &&
             req_data.point_index == req_data.point_total - 8'd1) begin
            used_ff[req_data.table_sel] <= (req_data.point_total > MaxP) ?
                                           MaxP : req_data.point_total;
         end
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         cur_pt = mem_q_ff;
      end else begin
         cur_pt      = '0;
         cur_pt.freq = rd_zero_ff ? fcit_pkg::DefaultFreq : '0;
      end
   end

   assign n10    = {rem10_ff, sh_ff[fcit_pkg::HzWidth-1 -: fcit_pkg::Div10Chunk]};
   assign prod10 = n10 * fcit_pkg::Recip10;
   assign q10    = prod10[fcit_pkg::Recip10Shift +: fcit_pkg::Div10Chunk];
   assign back10 = NW'(q10) * NW'(fcit_pkg::HzPerLsb);

   assign used_sel = used_ff[tsel_ff];
   assign used_eff = (used_sel == 8'd0) ? 8'd1 : ((used_sel > MaxP) ? MaxP : used_sel);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tsel_ff  <= req_data.table_sel;
         sh_ff    <= req_data.query_freq_hz;
         rem10_ff <= '0;
      end else if (cmd.div10_step) begin
         sh_ff    <= {sh_ff[fcit_pkg::HzWidth-fcit_pkg::Div10Chunk-1:0], q10};
         rem10_ff <= 4'(n10 - back10);
      end
      if (cmd.search_init) begin
         idx_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff  <= idx_ff + 8'd1;
      end
      if (cmd.advance) begin
         prev_ff <= cur_pt;
      end
   end

   assign status.hit      = ({8'd0, cur_pt.freq} >= sh_ff);
   assign status.idx_zero = (idx_ff == 8'd0);
   assign status.at_end   = (idx_ff == used_eff);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign num   = sh_ff[fcit_pkg::FreqWidth-1:0] - prev_ff.freq;
   assign diff1 = 17'(cur_pt.p1) - 17'(prev_ff.p1);
   assign diff2 = 17'(cur_pt.p2) - 17'(prev_ff.p2);
   assign prod1 = 51'(diff1 * $signed({1'b0, num}));
   assign prod2 = 51'(diff2 * $signed({1'b0, num}));

   assign rsh1 = {rem1_ff, dvd1_ff[fcit_pkg::ProdWidth-1]};
   assign rsh2 = {rem2_ff, dvd2_ff[fcit_pkg::ProdWidth-1]};
   assign ge1  = (rsh1 >= {1'b0, den_ff});
   assign ge2  = (rsh2 >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         den_ff  <= cur_pt.freq - prev_ff.freq;
         sgn1_ff <= prod1[50];
         sgn2_ff <= prod2[50];
         dvd1_ff <= prod1[50] ? 48'(-prod1) : prod1[47:0];
         dvd2_ff <= prod2[50] ? 48'(-prod2) : prod2[47:0];
         rem1_ff <= '0;
         rem2_ff <= '0;
      end else if (cmd.div_step) begin
         dvd1_ff <= {dvd1_ff[fcit_pkg::ProdWidth-2:0], ge1};
         dvd2_ff <= {dvd2_ff[fcit_pkg::ProdWidth-2:0], ge2};
         rem1_ff <= ge1 ? 32'(rsh1 - {1'b0, den_ff}) : rsh1[31:0];
         rem2_ff <= ge2 ? 32'(rsh2 - {1'b0, den_ff}) : rsh2[31:0];
      end
   end

   assign q1   = sgn1_ff ? -$signed({1'b0, dvd1_ff[16:0]}) : $signed({1'b0, dvd1_ff[16:0]});
   assign q2   = sgn2_ff ? -$signed({1'b0, dvd2_ff[16:0]}) : $signed({1'b0, dvd2_ff[16:0]});
   assign sum1 = 18'(prev_ff.p1) + q1;
   assign sum2 = 18'(prev_ff.p2) + q2;

   always_comb begin
      case (cmd.res_sel)
         fcit_pkg::SEL_CUR:  rsp_in = {cur_pt.p1, cur_pt.p2};
         fcit_pkg::SEL_PREV: rsp_in = {prev_ff.p1, prev_ff.p2};
         fcit_pkg::SEL_LERP: rsp_in = {sum1[15:0], sum2[15:0]};
         default:            rsp_in = {cur_pt.p1, cur_pt.p2};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.res_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/freq_correction_interpolation_table_top.sv @@
// Top level of the frequency correction interpolation table.
// Joins fcit_ctrl and fcit_dpath; depends on fcit_pkg.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | fcit_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready | fcit_pkg::rsp_type
//
// A write word is taken while the controller stays idle. A query runs the
// divide by ten, eight bits a cycle by reciprocal multiply, then reads and
// compares each table point scanned on the single memory port, then runs a
// multiply and shift-subtract divide when it interpolates, then loads the result.
// Reset clears the per-entry valid bits and sets both used counts to one.
// A waiting result holds in the output register while new words are taken.
module freq_correction_interpolation_table_top #(
   parameter int MAX_POINTS = fcit_pkg::MaxPointsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fcit_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fcit_pkg::rsp_type rsp_data
);

   fcit_pkg::dp_cmd_type    cmd;
   fcit_pkg::dp_status_type status;

   fcit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .status    (status),
      .cmd       (cmd)
   );

   fcit_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd == fcit_pkg::CmdQuery) |=> !req_ready)
      else $error("ready after query accept");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (!rsp_valid || rsp_ready)) |=> !rsp_valid)
      else $error("result too early");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd == fcit_pkg::CmdWrite) |=> req_ready)
      else $error("write stalled");
`endif

endmodule
